@@ sv/bencode_stream_tokenizer_defines.svh @@
// ----------------------------------------------------------------------------
// Bencode tokenizer assertion macros
// Shared property forms for the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef BENCODE_STREAM_TOKENIZER_DEFINES_SVH
`define BENCODE_STREAM_TOKENIZER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode tokenizer package
// Token kinds, error codes, parse modes and the token record.
// ----------------------------------------------------------------------------
package bst_pkg;

	typedef enum logic [2:0] {
		TK_INT = 3'd0, TK_HDR = 3'd1, TK_BYTE = 3'd2, TK_LIST = 3'd3,
		TK_DICT = 3'd4, TK_CLOSE = 3'd5, TK_ERR = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ER_NONE = 3'd0, ER_START = 3'd1, ER_TERM = 3'd2, ER_STR = 3'd3,
		ER_LIST = 3'd4, ER_DEPTH = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		M_VALUE, M_KEY, M_INT_SIGN, M_INT_DIGITS, M_LEN, M_DATA, M_DONE, M_ERROR
	} mode_t;

	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} item_t;

	typedef struct packed {
		kind_t        kind;
		logic [63:0]  value;
		logic [7:0]   sbyte;
		logic [5:0]   depth;
		logic         key;
		err_t         err;
		logic         done;
	} token_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

@@ sv/bst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bst_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/bst_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode tokenizer front end
// Two-entry input queue; hands items to the parser one per cycle while it is ready.
// ----------------------------------------------------------------------------
`include "bencode_stream_tokenizer_defines.svh"
module bst_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bst_pkg::item_t in_item,
	output logic           full,
	output logic           deq_valid,
	output bst_pkg::item_t deq_item,
	input  logic           deq_ready
);
	bst_pkg::item_t buf_q [2];
	logic           rd_q, wr_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_pop;

	assign full      = cnt_q[1];
	assign deq_valid = cnt_q != 2'd0;
	assign deq_item  = buf_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = deq_valid && deq_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	`BST_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3, "queue count overrun")
	`BST_ASSERT_NEXT(a_push_cnt, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + 2'd1,
		"push lost")
	`BST_ASSERT_IMP(a_ptr, clk, arst_n, cnt_q == 2'd0, rd_q == wr_q, "pointers disagree")
endmodule

@@ sv/bst_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode tokenizer parser
// Parse state machine, frame stack in RAM with cached top, token output queue.
// ----------------------------------------------------------------------------
`include "bencode_stream_tokenizer_defines.svh"
module bst_back #(
	parameter int STACK_DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [5:0]      depth_limit,
	input  logic            in_valid,
	input  bst_pkg::item_t  in_item,
	output logic            in_ready,
	output logic            empty,
	output bst_pkg::token_t tok,
	input  logic            pop
);
	localparam int RD = (STACK_DEPTH > 1) ? STACK_DEPTH : 2;
	localparam int AW = $clog2(RD);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	bst_pkg::mode_t  mode_q, mode_nx;
	logic [63:0]     acc_q, acc_nx, rem_q, rem_nx;
	logic            neg_q, neg_nx, key_q, key_nx;
	logic [DW-1:0]   sp_q, sp_nx;
	logic [1:0]      top_q, top_nx;
	logic            emit;
	bst_pkg::token_t t;
	logic            push_fr, pop_fr;
	logic [1:0]      push_kind;
	logic [1:0]      ram_rd;
	logic [AW-1:0]   ram_raddr, ram_waddr;
	logic            refill_q;

	// output two-entry queue
	bst_pkg::token_t obuf_q [2];
	logic            ord_q, owr_q;
	logic [1:0]      ocnt_q;
	logic            step;

	logic [7:0]      b;
	logic [DW-1:0]   lim;
	logic [63:0]     acc10;

	assign b      = in_item.data_byte;
	assign in_ready = !ocnt_q[1] && !refill_q;
	assign step   = in_valid && in_ready;
	assign empty  = ocnt_q == 2'd0;
	assign tok    = obuf_q[ord_q];
	assign acc10  = (acc_q << 3) + (acc_q << 1) + {56'd0, b} - 64'd48;

	always_comb begin
		if ({26'd0, depth_limit} > STACK_DEPTH) lim = DW'(STACK_DEPTH);
		else lim = DW'(depth_limit);
	end

	// frame stack: entries below the top, top held in top_q
	assign ram_waddr = AW'(sp_q - DW'(1));
	assign ram_raddr = AW'(sp_q - DW'(2));
	bst_ram #(.WIDTH(2), .DEPTH(RD)) u_stack (
		.clk(clk), .we(push_fr && sp_q != '0), .waddr(ram_waddr), .wdata(top_q),
		.raddr(ram_raddr), .rdata(ram_rd)
	);

	always_comb begin
		mode_nx = mode_q; acc_nx = acc_q; rem_nx = rem_q; neg_nx = neg_q;
		key_nx = key_q; sp_nx = sp_q; top_nx = top_q;
		emit = 1'b0; push_fr = 1'b0; pop_fr = 1'b0; push_kind = 2'd0;
		t = '{kind: bst_pkg::TK_ERR, value: 64'd0, sbyte: 8'd0, depth: 6'(sp_q),
			key: 1'b0, err: bst_pkg::ER_NONE, done: 1'b0};
		if (refill_q) top_nx = ram_rd;
		if (step) begin
			if (in_item.end_of_buffer) begin
				t.done = 1'b1;
				unique case (mode_q)
					bst_pkg::M_VALUE: begin
						emit = 1'b1;
						if (sp_q == '0) t.err = bst_pkg::ER_START;
						else if (top_q == 2'd1) t.err = bst_pkg::ER_LIST;
						else t.err = bst_pkg::ER_TERM;
					end
					bst_pkg::M_KEY, bst_pkg::M_INT_SIGN, bst_pkg::M_INT_DIGITS,
					bst_pkg::M_LEN: begin
						emit = 1'b1; t.err = bst_pkg::ER_TERM;
					end
					bst_pkg::M_DATA: begin
						emit = 1'b1; t.err = bst_pkg::ER_STR;
					end
					default: emit = 1'b0;
				endcase
				t.depth = 6'(sp_q);
				mode_nx = bst_pkg::M_VALUE; acc_nx = '0; neg_nx = 1'b0; rem_nx = '0;
				sp_nx = '0; key_nx = 1'b0; top_nx = 2'd0;
			end else begin
				unique case (mode_q)
					bst_pkg::M_VALUE, bst_pkg::M_KEY: begin
						if (mode_q == bst_pkg::M_VALUE && b == bst_pkg::CH_I) begin
							acc_nx = '0; neg_nx = 1'b0; mode_nx = bst_pkg::M_INT_SIGN;
						end else if (bst_pkg::is_digit(b)) begin
							acc_nx = {56'd0, b} - 64'd48;
							key_nx = mode_q == bst_pkg::M_KEY;
							mode_nx = bst_pkg::M_LEN;
						end else if (mode_q == bst_pkg::M_VALUE &&
								(b == bst_pkg::CH_L || b == bst_pkg::CH_D)) begin
							emit = 1'b1;
							if (sp_q >= lim) begin
								t.err = bst_pkg::ER_DEPTH; t.done = 1'b1;
								mode_nx = bst_pkg::M_ERROR;
							end else begin
								push_fr = 1'b1;
								push_kind = (b == bst_pkg::CH_L) ? 2'd1 : 2'd2;
								sp_nx = sp_q + DW'(1); top_nx = push_kind;
								t.depth = 6'(sp_nx);
								t.kind = (b == bst_pkg::CH_L) ? bst_pkg::TK_LIST
									: bst_pkg::TK_DICT;
								mode_nx = (b == bst_pkg::CH_L) ? bst_pkg::M_VALUE
									: bst_pkg::M_KEY;
							end
						end else if (b == bst_pkg::CH_E && sp_q != '0 &&
								(mode_q == bst_pkg::M_KEY || top_q == 2'd1)) begin
							emit = 1'b1; pop_fr = 1'b1;
							t.kind = bst_pkg::TK_CLOSE;
							sp_nx = sp_q - DW'(1);
							top_nx = 2'd0;
							if (sp_nx == '0) begin
								t.done = 1'b1; mode_nx = bst_pkg::M_DONE;
							end else begin
								mode_nx = bst_pkg::M_VALUE; // refined after refill
							end
						end else begin
							emit = 1'b1; t.err = bst_pkg::ER_START; t.done = 1'b1;
							mode_nx = bst_pkg::M_ERROR;
						end
					end
					bst_pkg::M_INT_SIGN, bst_pkg::M_INT_DIGITS: begin
						if (mode_q == bst_pkg::M_INT_SIGN && b == bst_pkg::CH_MINUS) begin
							neg_nx = 1'b1; mode_nx = bst_pkg::M_INT_DIGITS;
						end else if (b == bst_pkg::CH_E) begin
							emit = 1'b1; t.kind = bst_pkg::TK_INT;
							t.value = neg_q ? (64'd0 - acc_q) : acc_q;
							if (sp_q == '0) begin
								t.done = 1'b1; mode_nx = bst_pkg::M_DONE;
							end else begin
								mode_nx = (top_q == 2'd2) ? bst_pkg::M_KEY : bst_pkg::M_VALUE;
							end
						end else begin
							acc_nx = acc10; mode_nx = bst_pkg::M_INT_DIGITS;
						end
					end
					bst_pkg::M_LEN: begin
						if (b == bst_pkg::CH_COLON) begin
							emit = 1'b1; t.kind = bst_pkg::TK_HDR; t.value = acc_q;
							t.key = key_q; rem_nx = acc_q;
							if (acc_q == '0) begin
								if (sp_q == '0) begin
									t.done = 1'b1; mode_nx = bst_pkg::M_DONE;
								end else if (top_q == 2'd2) begin
									mode_nx = key_q ? bst_pkg::M_VALUE : bst_pkg::M_KEY;
								end else begin
									mode_nx = bst_pkg::M_VALUE;
								end
							end else begin
								mode_nx = bst_pkg::M_DATA;
							end
						end else begin
							acc_nx = acc10;
						end
					end
					bst_pkg::M_DATA: begin
						emit = 1'b1; t.kind = bst_pkg::TK_BYTE; t.sbyte = b;
						t.key = key_q; rem_nx = rem_q - 64'd1;
						if (rem_nx == '0) begin
							if (sp_q == '0) begin
								t.done = 1'b1; mode_nx = bst_pkg::M_DONE;
							end else if (top_q == 2'd2) begin
								mode_nx = key_q ? bst_pkg::M_VALUE : bst_pkg::M_KEY;
							end else begin
								mode_nx = bst_pkg::M_VALUE;
							end
						end
					end
					default: emit = 1'b0;
				endcase
			end
		end
	end

	// after a close, the new top is read from RAM in the following refill cycle; mode follows it
	logic close_pend_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bst_pkg::M_VALUE; acc_q <= '0; rem_q <= '0; neg_q <= 1'b0;
			key_q <= 1'b0; sp_q <= '0; top_q <= 2'd0; refill_q <= 1'b0;
			close_pend_q <= 1'b0;
		end else begin
			acc_q <= acc_nx; rem_q <= rem_nx; neg_q <= neg_nx; key_q <= key_nx;
			sp_q <= sp_nx; top_q <= top_nx;
			refill_q <= pop_fr && sp_nx != '0;
			close_pend_q <= pop_fr && sp_nx != '0;
			if (close_pend_q)
				mode_q <= (ram_rd == 2'd2) ? bst_pkg::M_KEY : bst_pkg::M_VALUE;
			else
				mode_q <= mode_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) obuf_q[owr_q] <= t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_q <= 1'b0; owr_q <= 1'b0; ocnt_q <= 2'd0;
		end else begin
			if (emit) owr_q <= !owr_q;
			if (pop && !empty) ord_q <= !ord_q;
			ocnt_q <= ocnt_q + {1'b0, emit} - {1'b0, pop && !empty};
		end
	end

	`BST_ASSERT_IMP(a_no_ovf, clk, arst_n, emit, ocnt_q != 2'd2, "token queue overflow")
	`BST_ASSERT_IMP(a_sp_lim, clk, arst_n, 1'b1, sp_q <= DW'(STACK_DEPTH), "stack past depth")
	`BST_ASSERT_IMP(a_refill, clk, arst_n, refill_q, !step, "item taken during refill")
endmodule

@@ sv/bencode_stream_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode stream tokenizer
// Bytes in, tokens out, through queue-style ports on both sides.
// ----------------------------------------------------------------------------
// One byte transfers per cycle; a close token that leaves containers still
// open stalls input while the new stack top is read from the frame RAM,
// and a full token queue stalls input. Each byte is registered in the
// input queue and its token in the token queue. No clearing pass after reset.
module bencode_stream_tokenizer #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  token_kind,
	output logic signed [63:0] token_value,
	output logic [7:0]  string_byte,
	output logic [5:0]  nest_depth,
	output logic        is_key,
	output logic [2:0]  error_code,
	output logic        value_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	logic [5:0]      limit_q;
	logic            qv, qr;
	bst_pkg::item_t  qi, ii;
	bst_pkg::token_t tk;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= 6'd32;
		else if (cfg_valid) limit_q <= cfg_data;
	end

	assign ii = '{data_byte: data_byte, end_of_buffer: end_of_buffer};

	bst_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .in_item(ii), .full(full),
		.deq_valid(qv), .deq_item(qi), .deq_ready(qr)
	);

	bst_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .depth_limit(limit_q), .in_valid(qv),
		.in_item(qi), .in_ready(qr), .empty(empty), .tok(tk), .pop(pop)
	);

	assign token_kind  = tk.kind;
	assign token_value = tk.value;
	assign string_byte = tk.sbyte;
	assign nest_depth  = tk.depth;
	assign is_key      = tk.key;
	assign error_code  = tk.err;
	assign value_done  = tk.done;
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bencode stream tokenizer testbench
// Random and directed bencoded buffers go in through the byte queue port;
// every token that comes out is checked against a token predictor kept in
// step with each byte transfer.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          NEST_MAX = 32;
	localparam int          DOG_LIMIT = 4000;
	localparam logic [1:0]  FR_LIST = 2'd1;
	localparam logic [1:0]  FR_DICT = 2'd2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_buffer = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  token_kind;
	logic signed [63:0] token_value;
	logic [7:0]  string_byte;
	logic [5:0]  nest_depth;
	logic        is_key;
	logic [2:0]  error_code;
	logic        value_done;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = 6'd0;

	always #6 clk = ~clk;

	bencode_stream_tokenizer #(.STACK_DEPTH(NEST_MAX)) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_byte(data_byte), .end_of_buffer(end_of_buffer),
		.empty(empty), .pop(pop), .token_kind(token_kind),
		.token_value(token_value), .string_byte(string_byte),
		.nest_depth(nest_depth), .is_key(is_key), .error_code(error_code),
		.value_done(value_done), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	bst_pkg::item_t  bytes_pending[$];
	bst_pkg::token_t tokens_due[$];
	logic [7:0]      txt[$];
	int              n_in = 0;
	int              n_err = 0;
	int              dog = 0;
	int              phase_lim = 32;

	// token predictor state
	logic [5:0]      lim_r;
	bst_pkg::mode_t  md;
	logic [63:0]     acc, remain;
	logic            neg, keyf;
	logic [1:0]      frames[NEST_MAX];
	int              sdepth;

	task automatic clear_parse();
		md = bst_pkg::M_VALUE;
		acc = '0;
		neg = 1'b0;
		remain = '0;
		keyf = 1'b0;
		sdepth = 0;
		foreach (frames[i]) frames[i] = 2'd0;
	endtask

	function automatic logic [1:0] top_fr();
		return (sdepth == 0) ? 2'd0 : frames[sdepth-1];
	endfunction

	function automatic bst_pkg::token_t mk(bst_pkg::kind_t k, logic [63:0] v,
			logic [7:0] sb, logic ky, bst_pkg::err_t e, logic dn);
		bst_pkg::token_t t;
		t.kind = k;
		t.value = v;
		t.sbyte = sb;
		t.depth = sdepth[5:0];
		t.key = ky;
		t.err = e;
		t.done = dn;
		return t;
	endfunction

	// value finished at current depth: pick next mode
	task automatic settle(input logic was_key, output logic dn);
		dn = (sdepth == 0);
		if (sdepth == 0)
			md = bst_pkg::M_DONE;
		else if (top_fr() == FR_DICT)
			md = was_key ? bst_pkg::M_VALUE : bst_pkg::M_KEY;
		else
			md = bst_pkg::M_VALUE;
	endtask

	task automatic fail(input bst_pkg::err_t e, output bst_pkg::token_t t);
		t = mk(bst_pkg::TK_ERR, '0, '0, 1'b0, e, 1'b1);
		md = bst_pkg::M_ERROR;
	endtask

	task automatic open_frame(input logic [1:0] fr, output bst_pkg::token_t t);
		int lim;
		lim = (lim_r > NEST_MAX) ? NEST_MAX : lim_r;
		if (sdepth >= lim) begin
			fail(bst_pkg::ER_DEPTH, t);
		end else begin
			frames[sdepth] = fr;
			sdepth++;
			t = mk(fr == FR_LIST ? bst_pkg::TK_LIST : bst_pkg::TK_DICT, '0, '0, 1'b0,
				bst_pkg::ER_NONE, 1'b0);
			md = (fr == FR_LIST) ? bst_pkg::M_VALUE : bst_pkg::M_KEY;
		end
	endtask

	task automatic close_frame(output bst_pkg::token_t t);
		logic dn;
		t = mk(bst_pkg::TK_CLOSE, '0, '0, 1'b0, bst_pkg::ER_NONE, 1'b0);
		sdepth--;
		settle(1'b0, dn);
		t.done = dn;
	endtask

	task automatic tokenize(input bst_pkg::item_t it, output bit got,
			output bst_pkg::token_t t);
		logic [7:0]    b;
		logic          dn, isdig;
		bst_pkg::err_t e;
		b = it.data_byte;
		isdig = (b >= bst_pkg::CH_ZERO) && (b <= bst_pkg::CH_NINE);
		got = 1'b0;
		t = '0;
		if (it.end_of_buffer) begin
			e = bst_pkg::ER_NONE;
			case (md)
				bst_pkg::M_VALUE: e = (sdepth == 0) ? bst_pkg::ER_START :
					(top_fr() == FR_LIST ? bst_pkg::ER_LIST : bst_pkg::ER_TERM);
				bst_pkg::M_KEY, bst_pkg::M_INT_SIGN, bst_pkg::M_INT_DIGITS,
				bst_pkg::M_LEN: e = bst_pkg::ER_TERM;
				bst_pkg::M_DATA: e = bst_pkg::ER_STR;
				default: e = bst_pkg::ER_NONE;
			endcase
			if (e != bst_pkg::ER_NONE) begin
				got = 1'b1;
				t = mk(bst_pkg::TK_ERR, '0, '0, 1'b0, e, 1'b1);
			end
			clear_parse();
		end else if (md == bst_pkg::M_INT_SIGN && b == bst_pkg::CH_MINUS) begin
			neg = 1'b1;
			md = bst_pkg::M_INT_DIGITS;
		end else if (md == bst_pkg::M_INT_SIGN || md == bst_pkg::M_INT_DIGITS) begin
			md = bst_pkg::M_INT_DIGITS;
			if (b == bst_pkg::CH_E) begin
				settle(1'b0, dn);
				t = mk(bst_pkg::TK_INT, neg ? -acc : acc, '0, 1'b0, bst_pkg::ER_NONE, dn);
				got = 1'b1;
			end else begin
				acc = acc * 64'd10 + {56'd0, b} - 64'd48;
			end
		end else begin
			case (md)
				bst_pkg::M_VALUE: begin
					if (b == bst_pkg::CH_I) begin
						acc = '0;
						neg = 1'b0;
						md = bst_pkg::M_INT_SIGN;
					end else if (isdig) begin
						acc = {56'd0, b} - 64'd48;
						keyf = 1'b0;
						md = bst_pkg::M_LEN;
					end else begin
						got = 1'b1;
						if (b == bst_pkg::CH_L) open_frame(FR_LIST, t);
						else if (b == bst_pkg::CH_D) open_frame(FR_DICT, t);
						else if (b == bst_pkg::CH_E && top_fr() == FR_LIST) close_frame(t);
						else fail(bst_pkg::ER_START, t);
					end
				end
				bst_pkg::M_KEY: begin
					if (isdig) begin
						acc = {56'd0, b} - 64'd48;
						keyf = 1'b1;
						md = bst_pkg::M_LEN;
					end else begin
						got = 1'b1;
						if (b == bst_pkg::CH_E) close_frame(t);
						else fail(bst_pkg::ER_START, t);
					end
				end
				bst_pkg::M_LEN: begin
					if (b == bst_pkg::CH_COLON) begin
						got = 1'b1;
						remain = acc;
						if (acc == 0) begin
							settle(keyf, dn);
							t = mk(bst_pkg::TK_HDR, acc, '0, keyf, bst_pkg::ER_NONE, dn);
						end else begin
							md = bst_pkg::M_DATA;
							t = mk(bst_pkg::TK_HDR, acc, '0, keyf, bst_pkg::ER_NONE, 1'b0);
						end
					end else begin
						acc = acc * 64'd10 + {56'd0, b} - 64'd48;
					end
				end
				bst_pkg::M_DATA: begin
					got = 1'b1;
					remain--;
					dn = 1'b0;
					if (remain == 0) settle(keyf, dn);
					t = mk(bst_pkg::TK_BYTE, '0, b, keyf, bst_pkg::ER_NONE, dn);
				end
				default: ;
			endcase
		end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
		n_err++;
	endtask

	// monitor: prediction on input transfers, checks on token transfers
	always @(posedge clk) begin
		bst_pkg::item_t  it;
		bst_pkg::token_t t, w;
		bit              got, moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				lim_r = cfg_data;
				moved = 1'b1;
			end
			if (push && !full) begin
				it = bytes_pending.pop_front();
				n_in++;
				tokenize(it, got, t);
				if (got) tokens_due.push_back(t);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				if (tokens_due.size() == 0) begin
					report("unexpected token kind", 64'(token_kind), 64'd0);
				end else begin
					w = tokens_due.pop_front();
					if (token_kind != w.kind)
						report("token_kind", 64'(token_kind), 64'(w.kind));
					if (token_value != w.value)
						report("token_value", token_value, w.value);
					if (string_byte != w.sbyte)
						report("string_byte", 64'(string_byte), 64'(w.sbyte));
					if (nest_depth != w.depth)
						report("nest_depth", 64'(nest_depth), 64'(w.depth));
					if (is_key != w.key)
						report("is_key", 64'(is_key), 64'(w.key));
					if (error_code != w.err)
						report("error_code", 64'(error_code), 64'(w.err));
					if (value_done != w.done)
						report("value_done", 64'(value_done), 64'(w.done));
				end
			end
			if (moved || (bytes_pending.size() == 0 && tokens_due.size() == 0))
				dog = 0;
			else
				dog++;
			if (dog >= DOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// driver: inputs move on the falling edge
	always @(negedge clk) begin
		bit quiet;
		if (arst_n) begin
			quiet = (n_in >= 400 && n_in < 650);
			push <= (bytes_pending.size() != 0) && (quiet || $urandom_range(0, 99) >= 6);
			if (bytes_pending.size() != 0) begin
				data_byte <= bytes_pending[0].data_byte;
				end_of_buffer <= bytes_pending[0].end_of_buffer;
			end
			pop <= quiet || $urandom_range(0, 99) >= 6;
		end
	end

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			bytes_pending.push_back(bst_pkg::item_t'{s[i], 1'b0});
		bytes_pending.push_back(bst_pkg::item_t'{8'h00, 1'b1});
	endtask

	function automatic void put_digits(int n);
		repeat (n)
			txt.push_back($urandom_range(0, 19) == 0 ? 8'($urandom) :
				bst_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void gen_string();
		int len;
		len = $urandom_range(0, 5);
		if ($urandom_range(0, 7) == 0) txt.push_back(bst_pkg::CH_ZERO);
		txt.push_back(bst_pkg::CH_ZERO + 8'(len));
		txt.push_back(bst_pkg::CH_COLON);
		repeat (len) txt.push_back(8'($urandom));
	endfunction

	function automatic void gen_value(int lvl);
		int r, n;
		r = (lvl < 5) ? $urandom_range(0, 9) : $urandom_range(0, 4);
		n = $urandom_range(0, 3);
		if (r < 3) begin
			txt.push_back(bst_pkg::CH_I);
			if ($urandom_range(0, 2) == 0) txt.push_back(bst_pkg::CH_MINUS);
			put_digits($urandom_range(0, 9) == 0 ? $urandom_range(15, 22) : $urandom_range(0, 4));
			txt.push_back(bst_pkg::CH_E);
		end else if (r < 5) begin
			gen_string();
		end else if (r < 8) begin
			txt.push_back(bst_pkg::CH_L);
			repeat (n) gen_value(lvl + 1);
			txt.push_back(bst_pkg::CH_E);
		end else begin
			txt.push_back(bst_pkg::CH_D);
			repeat (n) begin
				gen_string();
				gen_value(lvl + 1);
			end
			txt.push_back(bst_pkg::CH_E);
		end
	endfunction

	task automatic gen_buffer();
		int r, n, eff;
		txt.delete();
		r = $urandom_range(0, 99);
		eff = (phase_lim > NEST_MAX) ? NEST_MAX : phase_lim;
		if (r < 4) begin
			repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom));
		end else if (r < 9) begin
			n = eff + $urandom_range(0, 2) - 1;
			if (n < 1) n = 1;
			repeat (n) txt.push_back($urandom_range(0, 1) ? bst_pkg::CH_L : bst_pkg::CH_D);
			repeat (n) txt.push_back(bst_pkg::CH_E);
		end else if (r < 11) begin
			txt.delete();
		end else begin
			gen_value(0);
		end
		if ($urandom_range(0, 99) < 8)
			repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom));
		if (txt.size() > 1 && $urandom_range(0, 99) < 8)
			txt = txt[0:$urandom_range(0, txt.size() - 2)];
		if (txt.size() > 0 && $urandom_range(0, 99) < 8)
			txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
		foreach (txt[i]) bytes_pending.push_back(bst_pkg::item_t'{txt[i], 1'b0});
		bytes_pending.push_back(bst_pkg::item_t'{8'h00, 1'b1});
	endtask

	task automatic drain();
		wait (bytes_pending.size() == 0 && tokens_due.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(int v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= 6'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		phase_lim = v;
	endtask

	initial begin
		int    limits[7];
		string deep;
		limits = '{32, 1, 2, 0, 63, 5, 32};
		lim_r = 6'd32;
		clear_parse();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_text("ie");
		send_text("i-e");
		send_text("i-9223372036854775809e");
		send_text("0:");
		send_text({"2:", 8'hFF, 8'h00});
		send_text("d1:ali0eee");
		send_text("e");
		send_text("dxe");
		send_text("d1:ae");
		send_text("li0e");
		send_text("d");
		send_text("i12");
		send_text("5:ab");
		send_text("");
		send_text("i1eXYZ");
		send_text("de");
		deep = "";
		repeat (33) deep = {deep, "l"};
		send_text(deep);
		drain();

		foreach (limits[p]) begin
			write_limit(limits[p]);
			while (n_in + bytes_pending.size() < 150 * (p + 1)) begin
				gen_buffer();
				wait (bytes_pending.size() < 40);
			end
			drain();
		end

		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
